### hdl/variable_partition_allocator_assert.svh
// Assertion macros for the variable partition allocator.
`ifndef VARIABLE_PARTITION_ALLOCATOR_ASSERT_SVH
`define VARIABLE_PARTITION_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, checked on clk and disabled in reset.
`define VPA_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on clk and disabled in reset.
`define VPA_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/vpa_pkg.sv
// Shared constants, codes and controller/datapath types for the allocator.
`default_nettype none
package vpa_pkg;
    localparam int HOLE_ENTRIES = 16;
    localparam int USED_ENTRIES = 16;
    localparam int ADDR_BITS    = 16;

    localparam int HIDX_W = $clog2(HOLE_ENTRIES);
    localparam int HCNT_W = $clog2(HOLE_ENTRIES + 1);
    localparam int UIDX_W = $clog2(USED_ENTRIES);
    localparam int UCNT_W = $clog2(USED_ENTRIES + 1);
    localparam int SCAN_W = (HCNT_W > UCNT_W) ? HCNT_W : UCNT_W;
    localparam int EXT_W  = ADDR_BITS + 17;

    localparam logic [1:0] REQ_ALLOC   = 2'd0;
    localparam logic [1:0] REQ_RELEASE = 2'd1;
    localparam logic [1:0] REQ_INIT    = 2'd2;

    localparam logic [1:0] POL_BEST  = 2'd1;
    localparam logic [1:0] POL_WORST = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOFIT    = 2'd1;
    localparam logic [1:0] ST_NOTFOUND = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    localparam logic CFG_BASE   = 1'b0;
    localparam logic CFG_LENGTH = 1'b1;

    localparam logic [3:0] OP_NONE    = 4'd0;
    localparam logic [3:0] OP_LOAD    = 4'd1;
    localparam logic [3:0] OP_ASCAN   = 4'd2;
    localparam logic [3:0] OP_ACOMMIT = 4'd3;
    localparam logic [3:0] OP_USCAN   = 4'd4;
    localparam logic [3:0] OP_RSTART  = 4'd5;
    localparam logic [3:0] OP_HSCAN   = 4'd6;
    localparam logic [3:0] OP_RCOMMIT = 4'd7;
    localparam logic [3:0] OP_INIT    = 4'd8;
    localparam logic [3:0] OP_NOP     = 4'd9;

    typedef struct packed {
        logic [3:0] op;
        logic       emit;
    } dp_cmd_t;

    typedef struct packed {
        logic [1:0]        req_type;
        logic              a_done;
        logic              u_done;
        logic              h_done;
        logic              out_free;
        logic [HCNT_W-1:0] hole_count;
    } dp_sts_t;
endpackage
`default_nettype wire

### hdl/variable_partition_allocator.sv
// Top level of the variable partition allocator: controller, datapath and checks.
`default_nettype none
// The allocator manages one region of memory, counted in KB units, as variable
// partitions. A 16-entry hole table is kept packed and sorted by address, and a
// 16-entry table of allocated blocks carries the owning job id of each block.
// An allocate item picks a hole by first, best or worst fit and carves the block
// from the hole's low end; a release item frees the lowest-addressed block of the
// job and merges it with neighboring holes; an initialize item clears both tables
// and makes the configured region the only hole. Every input item gives exactly
// one result item. Items are handled one at a time: an allocate walks the hole
// table, and a release walks the block table and then the hole table, one entry
// per cycle through a single read port each. A new item is accepted as soon as
// the previous one has moved into the output register, even while that result
// is still stalled. Configuration writes take effect at once and are meant to be
// made while the block is idle.
module variable_partition_allocator (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [15:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  req_type,
    input  wire logic [7:0]  job_id,
    input  wire logic [15:0] req_length,
    input  wire logic [1:0]  fit_policy,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [1:0]       status,
    output logic [15:0]      block_start,
    output logic [15:0]      block_length
);
    import vpa_pkg::*;

    `include "variable_partition_allocator_assert.svh"

    dp_cmd_t cmd;
    dp_sts_t sts;

    // The controller only sequences; every table and decision lives in the datapath.
    vpa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    vpa_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .req_type     (req_type),
        .job_id       (job_id),
        .req_length   (req_length),
        .fit_policy   (fit_policy),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .block_start  (block_start),
        .block_length (block_length)
    );

    // The hole count can never grow past the table size.
    `VPA_ASSERT_IMP(a_hole_count, 1'b1, sts.hole_count <= HCNT_W'(HOLE_ENTRIES), "hole count overflow")
    // An accepted item keeps the input side closed in the following cycle.
    `VPA_ASSERT_NXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "second item accepted too early")
    // A failed request reports an empty block.
    `VPA_ASSERT_IMP(a_fail_zero, out_valid && status != ST_OK, block_start == '0 && block_length == '0, "failure with nonzero block")
endmodule
`default_nettype wire

### hdl/vpa_ctrl.sv
// Sequencing state machine of the allocator.
`default_nettype none
module vpa_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_stall,
    input  wire vpa_pkg::dp_sts_t sts,
    output vpa_pkg::dp_cmd_t     cmd
);
    import vpa_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DISP  = 3'd1;
    localparam logic [2:0] S_ASCAN = 3'd2;
    localparam logic [2:0] S_USCAN = 3'd3;
    localparam logic [2:0] S_HSCAN = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    logic [2:0] state_reg, state_next;

    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = OP_NONE;
        cmd.emit   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                case (sts.req_type)
                    REQ_ALLOC:   state_next = S_ASCAN;
                    REQ_RELEASE: state_next = S_USCAN;
                    REQ_INIT:
                    begin
                        cmd.op     = OP_INIT;
                        state_next = S_OUT;
                    end
                    default:
                    begin
                        cmd.op     = OP_NOP;
                        state_next = S_OUT;
                    end
                endcase
            end
            S_ASCAN:
            begin
                if (sts.a_done)
                begin
                    cmd.op     = OP_ACOMMIT;
                    state_next = S_OUT;
                end
                else
                begin
                    cmd.op = OP_ASCAN;
                end
            end
            S_USCAN:
            begin
                if (sts.u_done)
                begin
                    cmd.op     = OP_RSTART;
                    state_next = S_HSCAN;
                end
                else
                begin
                    cmd.op = OP_USCAN;
                end
            end
            S_HSCAN:
            begin
                if (sts.h_done)
                begin
                    cmd.op     = OP_RCOMMIT;
                    state_next = S_OUT;
                end
                else
                begin
                    cmd.op = OP_HSCAN;
                end
            end
            S_OUT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end
endmodule
`default_nettype wire

### hdl/vpa_dp.sv
// Datapath of the allocator: tables, scan counter, fit search and result register.
`default_nettype none
module vpa_dp (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire vpa_pkg::dp_cmd_t cmd,
    output vpa_pkg::dp_sts_t      sts,
    input  wire logic             cfg_we,
    input  wire logic             cfg_index,
    input  wire logic [15:0]      cfg_data,
    input  wire logic [1:0]       req_type,
    input  wire logic [7:0]       job_id,
    input  wire logic [15:0]      req_length,
    input  wire logic [1:0]       fit_policy,
    output logic                  out_valid,
    input  wire logic             out_stall,
    output logic [1:0]            status,
    output logic [15:0]           block_start,
    output logic [15:0]           block_length
);
    import vpa_pkg::*;

    logic [15:0] base_reg, rlen_reg;
    logic [1:0]  type_reg, pol_reg;
    logic [7:0]  job_reg;
    logic [15:0] len_reg;

    logic [SCAN_W-1:0] idx_reg, idx_next;
    logic [HCNT_W-1:0] n_reg, n_next;

    logic [15:0] hs_reg [HOLE_ENTRIES];
    logic [15:0] hl_reg [HOLE_ENTRIES];
    logic [15:0] hs_next [HOLE_ENTRIES];
    logic [15:0] hl_next [HOLE_ENTRIES];

    logic [15:0] us_reg [USED_ENTRIES];
    logic [15:0] ul_reg [USED_ENTRIES];
    logic [7:0]  uo_reg [USED_ENTRIES];
    logic [USED_ENTRIES-1:0] uv_reg, uv_next;
    logic              u_we;
    logic [UIDX_W-1:0] u_waddr;

    logic              pick_found_reg, pick_found_next;
    logic [HIDX_W-1:0] pick_idx_reg, pick_idx_next;
    logic [15:0]       pick_start_reg, pick_start_next;
    logic [15:0]       pick_len_reg, pick_len_next;

    logic              k_found_reg, k_found_next;
    logic [UIDX_W-1:0] k_reg, k_next;
    logic [15:0]       bs_reg, bs_next, bl_reg, bl_next;

    logic              prev_found_reg, prev_found_next;
    logic [16:0]       prev_end_reg, prev_end_next;
    logic [15:0]       prev_len_reg, prev_len_next;

    logic [1:0]  res_st_reg, res_st_next;
    logic [15:0] res_start_reg, res_start_next, res_len_reg, res_len_next;
    logic        out_valid_reg;
    logic [1:0]  out_st_reg;
    logic [15:0] out_start_reg, out_len_reg;

    logic [HIDX_W-1:0] hidx;
    logic [UIDX_W-1:0] uidx;
    logic              in_holes;
    logic [15:0]       cur_start, cur_len;
    logic              fits, first_pol;
    logic              slot_found;
    logic [UIDX_W-1:0] slot;
    logic              below, above;
    logic [HIDX_W-1:0] ins_idx, low_idx;
    logic [EXT_W-1:0]  limit, base_e, room, len_e, init_len;

    assign hidx      = idx_reg[HIDX_W-1:0];
    assign uidx      = idx_reg[UIDX_W-1:0];
    assign in_holes  = (idx_reg < SCAN_W'(n_reg));
    assign cur_start = hs_reg[hidx];
    assign cur_len   = hl_reg[hidx];
    assign fits      = (cur_len >= len_reg);
    assign first_pol = !(pol_reg inside {POL_BEST, POL_WORST});
    assign ins_idx   = idx_reg[HIDX_W-1:0];
    assign low_idx   = HIDX_W'(idx_reg - SCAN_W'(1));

    assign below = prev_found_reg && (prev_end_reg == {1'b0, bs_reg});
    assign above = in_holes && (({1'b0, bs_reg} + {1'b0, bl_reg}) == {1'b0, cur_start});

    assign limit    = EXT_W'(1) << ADDR_BITS;
    assign base_e   = EXT_W'(base_reg) & (limit - EXT_W'(1));
    assign room     = limit - base_e;
    assign len_e    = EXT_W'(rlen_reg);
    assign init_len = (len_e > room) ? room : len_e;

    always_comb
    begin
        slot_found = 1'b0;
        slot       = '0;
        for (int j = USED_ENTRIES - 1; j >= 0; j--)
        begin
            if (!uv_reg[j])
            begin
                slot_found = 1'b1;
                slot       = UIDX_W'(j);
            end
        end
    end

    assign sts.req_type   = type_reg;
    assign sts.a_done     = !in_holes || (first_pol && pick_found_reg);
    assign sts.u_done     = (idx_reg == SCAN_W'(USED_ENTRIES));
    assign sts.h_done     = !in_holes || (cur_start > bs_reg);
    assign sts.out_free   = !out_valid_reg || !out_stall;
    assign sts.hole_count = n_reg;

    always_comb
    begin
        idx_next        = idx_reg;
        n_next          = n_reg;
        hs_next         = hs_reg;
        hl_next         = hl_reg;
        uv_next         = uv_reg;
        u_we            = 1'b0;
        u_waddr         = slot;
        pick_found_next = pick_found_reg;
        pick_idx_next   = pick_idx_reg;
        pick_start_next = pick_start_reg;
        pick_len_next   = pick_len_reg;
        k_found_next    = k_found_reg;
        k_next          = k_reg;
        bs_next         = bs_reg;
        bl_next         = bl_reg;
        prev_found_next = prev_found_reg;
        prev_end_next   = prev_end_reg;
        prev_len_next   = prev_len_reg;
        res_st_next     = res_st_reg;
        res_start_next  = res_start_reg;
        res_len_next    = res_len_reg;
        case (cmd.op)
            OP_LOAD:
            begin
                idx_next        = '0;
                pick_found_next = 1'b0;
                k_found_next    = 1'b0;
                prev_found_next = 1'b0;
            end
            OP_ASCAN:
            begin
                idx_next = idx_reg + SCAN_W'(1);
                if (fits && (first_pol || !pick_found_reg
                        || (pol_reg == POL_BEST && cur_len < pick_len_reg)
                        || (pol_reg == POL_WORST && cur_len > pick_len_reg)))
                begin
                    pick_found_next = 1'b1;
                    pick_idx_next   = hidx;
                    pick_start_next = cur_start;
                    pick_len_next   = cur_len;
                end
            end
            OP_ACOMMIT:
            begin
                res_start_next = '0;
                res_len_next   = '0;
                if (len_reg == '0 || !pick_found_reg)
                begin
                    res_st_next = ST_NOFIT;
                end
                else if (!slot_found)
                begin
                    res_st_next = ST_FULL;
                end
                else
                begin
                    u_we           = 1'b1;
                    uv_next[slot]  = 1'b1;
                    res_st_next    = ST_OK;
                    res_start_next = pick_start_reg;
                    res_len_next   = len_reg;
                    if (pick_len_reg == len_reg)
                    begin
                        // Exact fit: the hole disappears and the ones above close up.
                        for (int j = 0; j < HOLE_ENTRIES - 1; j++)
                        begin
                            if (HIDX_W'(j) >= pick_idx_reg)
                            begin
                                hs_next[j] = hs_reg[j + 1];
                                hl_next[j] = hl_reg[j + 1];
                            end
                        end
                        n_next = n_reg - HCNT_W'(1);
                    end
                    else
                    begin
                        hs_next[pick_idx_reg] = pick_start_reg + len_reg;
                        hl_next[pick_idx_reg] = pick_len_reg - len_reg;
                    end
                end
            end
            OP_USCAN:
            begin
                idx_next = idx_reg + SCAN_W'(1);
                if (uv_reg[uidx] && uo_reg[uidx] == job_reg
                        && (!k_found_reg || us_reg[uidx] < bs_reg))
                begin
                    k_found_next = 1'b1;
                    k_next       = uidx;
                    bs_next      = us_reg[uidx];
                    bl_next      = ul_reg[uidx];
                end
            end
            OP_RSTART:
            begin
                idx_next = '0;
            end
            OP_HSCAN:
            begin
                idx_next        = idx_reg + SCAN_W'(1);
                prev_found_next = 1'b1;
                prev_end_next   = {1'b0, cur_start} + {1'b0, cur_len};
                prev_len_next   = cur_len;
            end
            OP_RCOMMIT:
            begin
                res_st_next    = ST_OK;
                res_start_next = bs_reg;
                res_len_next   = bl_reg;
                if (!k_found_reg)
                begin
                    res_st_next    = ST_NOTFOUND;
                    res_start_next = '0;
                    res_len_next   = '0;
                end
                else if (!below && !above && n_reg == HCNT_W'(HOLE_ENTRIES))
                begin
                    res_st_next    = ST_FULL;
                    res_start_next = '0;
                    res_len_next   = '0;
                end
                else
                begin
                    uv_next[k_reg] = 1'b0;
                    if (below && above)
                    begin
                        hl_next[low_idx] = prev_len_reg + bl_reg + cur_len;
                        for (int j = 0; j < HOLE_ENTRIES - 1; j++)
                        begin
                            if (HIDX_W'(j) >= hidx)
                            begin
                                hs_next[j] = hs_reg[j + 1];
                                hl_next[j] = hl_reg[j + 1];
                            end
                        end
                        n_next = n_reg - HCNT_W'(1);
                    end
                    else if (below)
                    begin
                        hl_next[low_idx] = prev_len_reg + bl_reg;
                    end
                    else if (above)
                    begin
                        hs_next[hidx] = bs_reg;
                        hl_next[hidx] = cur_len + bl_reg;
                    end
                    else
                    begin
                        // Isolated block: open a gap at the insertion point.
                        for (int j = 1; j < HOLE_ENTRIES; j++)
                        begin
                            if (HIDX_W'(j) > ins_idx)
                            begin
                                hs_next[j] = hs_reg[j - 1];
                                hl_next[j] = hl_reg[j - 1];
                            end
                        end
                        hs_next[ins_idx] = bs_reg;
                        hl_next[ins_idx] = bl_reg;
                        n_next = n_reg + HCNT_W'(1);
                    end
                end
            end
            OP_INIT:
            begin
                uv_next        = '0;
                hs_next[0]     = base_e[15:0];
                hl_next[0]     = init_len[15:0];
                n_next         = (init_len != '0) ? HCNT_W'(1) : '0;
                res_st_next    = ST_OK;
                res_start_next = base_e[15:0];
                res_len_next   = init_len[15:0];
            end
            OP_NOP:
            begin
                res_st_next    = ST_OK;
                res_start_next = '0;
                res_len_next   = '0;
            end
            default:
            begin
                idx_next = idx_reg;
            end
        endcase
    end

    // Table contents and payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        hs_reg <= hs_next;
        hl_reg <= hl_next;
        if (u_we)
        begin
            us_reg[u_waddr] <= pick_start_reg;
            ul_reg[u_waddr] <= len_reg;
            uo_reg[u_waddr] <= job_reg;
        end
        if (cmd.op == OP_LOAD)
        begin
            type_reg <= req_type;
            job_reg  <= job_id;
            len_reg  <= req_length;
            pol_reg  <= fit_policy;
        end
        pick_idx_reg   <= pick_idx_next;
        pick_start_reg <= pick_start_next;
        pick_len_reg   <= pick_len_next;
        k_reg          <= k_next;
        bs_reg         <= bs_next;
        bl_reg         <= bl_next;
        prev_end_reg   <= prev_end_next;
        prev_len_reg   <= prev_len_next;
        res_st_reg     <= res_st_next;
        res_start_reg  <= res_start_next;
        res_len_reg    <= res_len_next;
        if (cmd.emit)
        begin
            out_st_reg    <= res_st_reg;
            out_start_reg <= res_start_reg;
            out_len_reg   <= res_len_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg        <= 16'd0;
            rlen_reg        <= 16'd1024;
            idx_reg         <= '0;
            n_reg           <= '0;
            uv_reg          <= '0;
            pick_found_reg  <= 1'b0;
            k_found_reg     <= 1'b0;
            prev_found_reg  <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we && cfg_index == CFG_BASE)
            begin
                base_reg <= cfg_data;
            end
            if (cfg_we && cfg_index == CFG_LENGTH)
            begin
                rlen_reg <= cfg_data;
            end
            idx_reg        <= idx_next;
            n_reg          <= n_next;
            uv_reg         <= uv_next;
            pick_found_reg <= pick_found_next;
            k_found_reg    <= k_found_next;
            prev_found_reg <= prev_found_next;
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = out_st_reg;
    assign block_start  = out_start_reg;
    assign block_length = out_len_reg;
endmodule
`default_nettype wire

### tb/tb_top.sv
// Testbench for the variable partition allocator: predictor, stimulus tasks and result checking.
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
    import vpa_pkg::*;

    // The hole and block tables are small, so the predictor keeps its own copy of both
    // tables at the block's widths. Every input item gives exactly one result item, which
    // is predicted when the item is accepted and queued until the block returns it.
    localparam int NH = 16;
    localparam int NU = 16;

    typedef struct packed {
        logic [1:0]  st;
        logic [15:0] start;
        logic [15:0] len;
    } grant_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic        cfg_index = 1'b0;
    logic [15:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  req_type = '0;
    logic [7:0]  job_id = '0;
    logic [15:0] req_length = '0;
    logic [1:0]  fit_policy = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [1:0]  status;
    logic [15:0] block_start;
    logic [15:0] block_length;

    // Predictor state.
    logic [15:0] m_base = 16'd0;
    logic [15:0] m_len = 16'd1024;
    logic [15:0] h_start [NH];
    logic [15:0] h_len [NH];
    int          h_cnt = 0;
    logic [15:0] u_start [NU];
    logic [15:0] u_len [NU];
    logic [7:0]  u_owner [NU];
    logic        u_used [NU];

    grant_t pending_grants[$];
    int     mismatches = 0;
    int     items_sent = 0;
    int     results_seen = 0;
    int     ok_allocs = 0;
    int     ok_releases = 0;
    int     long_hold = 0;
    logic   quiet_out = 1'b0;

    variable_partition_allocator u_dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .in_valid(in_valid), .in_stall(in_stall),
        .req_type(req_type), .job_id(job_id), .req_length(req_length),
        .fit_policy(fit_policy), .out_valid(out_valid), .out_stall(out_stall),
        .status(status), .block_start(block_start), .block_length(block_length)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int gap_len();
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(10, 40);
        if ($urandom_range(0, 2) == 0)
            return 0;
        return $urandom_range(0, 3);
    endfunction

    function automatic void drop_hole(int idx);
        for (int i = idx; i + 1 < h_cnt; i++)
        begin
            h_start[i] = h_start[i + 1];
            h_len[i] = h_len[i + 1];
        end
        h_cnt--;
    endfunction

    function automatic grant_t predict_grant(logic [1:0] kind, logic [7:0] job,
                                             logic [15:0] size, logic [1:0] pol);
        grant_t g;
        int pick;
        int slot;
        int k;
        int i;
        bit below;
        bit above;
        logic [16:0] room;
        logic [16:0] span;
        g = '{st: ST_OK, start: '0, len: '0};
        pick = -1;
        slot = -1;
        k = -1;
        if (kind == REQ_ALLOC)
        begin
            for (i = 0; i < h_cnt; i++)
            begin
                if (h_len[i] < size)
                    continue;
                if (pol == POL_BEST)
                begin
                    if (pick < 0 || h_len[i] < h_len[pick])
                        pick = i;
                end
                else if (pol == POL_WORST)
                begin
                    if (pick < 0 || h_len[i] > h_len[pick])
                        pick = i;
                end
                else
                begin
                    pick = i;
                    break;
                end
            end
            if (size == 0 || pick < 0)
            begin
                g.st = ST_NOFIT;
                return g;
            end
            for (i = 0; i < NU; i++)
                if (!u_used[i] && slot < 0)
                    slot = i;
            if (slot < 0)
            begin
                g.st = ST_FULL;
                return g;
            end
            u_start[slot] = h_start[pick];
            u_len[slot] = size;
            u_owner[slot] = job;
            u_used[slot] = 1'b1;
            g.start = h_start[pick];
            g.len = size;
            if (h_len[pick] == size)
                drop_hole(pick);
            else
            begin
                h_start[pick] += size;
                h_len[pick] -= size;
            end
        end
        else if (kind == REQ_RELEASE)
        begin
            for (i = 0; i < NU; i++)
                if (u_used[i] && u_owner[i] == job && (k < 0 || u_start[i] < u_start[k]))
                    k = i;
            if (k < 0)
            begin
                g.st = ST_NOTFOUND;
                return g;
            end
            i = 0;
            while (i < h_cnt && h_start[i] <= u_start[k])
                i++;
            below = i > 0 && ({1'b0, h_start[i - 1]} + h_len[i - 1]) == {1'b0, u_start[k]};
            above = i < h_cnt && ({1'b0, u_start[k]} + u_len[k]) == {1'b0, h_start[i]};
            if (below && above)
            begin
                h_len[i - 1] = h_len[i - 1] + u_len[k] + h_len[i];
                drop_hole(i);
            end
            else if (below)
                h_len[i - 1] = h_len[i - 1] + u_len[k];
            else if (above)
            begin
                h_start[i] = u_start[k];
                h_len[i] = h_len[i] + u_len[k];
            end
            else
            begin
                if (h_cnt >= NH)
                begin
                    g.st = ST_FULL;
                    return g;
                end
                for (int j = h_cnt; j > i; j--)
                begin
                    h_start[j] = h_start[j - 1];
                    h_len[j] = h_len[j - 1];
                end
                h_start[i] = u_start[k];
                h_len[i] = u_len[k];
                h_cnt++;
            end
            u_used[k] = 1'b0;
            g.start = u_start[k];
            g.len = u_len[k];
        end
        else if (kind == REQ_INIT)
        begin
            // The region is cut so that it does not run past the top of the address space.
            room = 17'h10000 - m_base;
            span = (m_len > room) ? room : {1'b0, m_len};
            h_cnt = 0;
            for (i = 0; i < NU; i++)
                u_used[i] = 1'b0;
            if (span != 0)
            begin
                h_start[0] = m_base;
                h_len[0] = span[15:0];
                h_cnt = 1;
            end
            g.start = m_base;
            g.len = span[15:0];
        end
        return g;
    endfunction

    // Drive one item, hold it until accepted, and record its prediction. The valid
    // line is dropped only when a gap follows, so back-to-back items never assign it
    // twice at the same edge.
    task automatic send_request(logic [1:0] kind, logic [7:0] job, logic [15:0] size,
                                logic [1:0] pol, bit no_gap = 0);
        grant_t g;
        int idle;
        idle = no_gap ? 0 : gap_len();
        if (idle > 0)
        begin
            in_valid <= 1'b0;
            repeat (idle) @(posedge clk);
        end
        in_valid <= 1'b1;
        req_type <= kind;
        job_id <= job;
        req_length <= size;
        fit_policy <= pol;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        g = predict_grant(kind, job, size, pol);
        if (g.st == ST_OK && kind == REQ_ALLOC)
            ok_allocs++;
        if (g.st == ST_OK && kind == REQ_RELEASE)
            ok_releases++;
        pending_grants.push_back(g);
        items_sent++;
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_grants.size() != 0)
            @(posedge clk);
        // A request whose result was already taken cannot still be in flight, and the block
        // is back at idle once its last result has moved into the output register.
        repeat (40) @(posedge clk);
    endtask

    task automatic write_config(logic idx, logic [15:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        if (idx == CFG_BASE)
            m_base = value;
        else
            m_len = value;
    endtask

    // Receiver side: random stalls, a long hold-off when asked, or no stalls while quiet.
    always @(posedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else if (long_hold > 0)
        begin
            out_stall <= 1'b1;
            long_hold <= long_hold - 1;
        end
        else if (quiet_out)
            out_stall <= 1'b0;
        else
            out_stall <= ($urandom_range(0, 3) == 0) ||
                         (out_stall && $urandom_range(0, 9) != 0 && $urandom_range(0, 1) == 0);
    end

    // Compare each accepted result with the oldest prediction.
    always @(posedge clk)
    begin
        grant_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (pending_grants.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: status %0d start %0h length %0h",
                             status, block_start, block_length);
            end
            else
            begin
                want = pending_grants.pop_front();
                if (status !== want.st || block_start !== want.start ||
                    block_length !== want.len)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %0d/%0h/%0h, got %0d/%0h/%0h",
                                 want.st, want.start, want.len,
                                 status, block_start, block_length);
                end
            end
        end
    end

    // Before any initialize there are no holes; every allocate must fail.
    task automatic test_before_init();
        send_request(REQ_ALLOC, 8'd1, 16'd1, 2'd0);
        send_request(REQ_ALLOC, 8'hFF, 16'hFFFF, POL_WORST);
        send_request(REQ_RELEASE, 8'd1, 16'd0, 2'd0);
        send_request(2'd3, 8'd0, 16'd0, 2'd0);
    endtask

    // Field extremes, every fit policy, exact fits and merges in all directions.
    task automatic test_directed();
        send_request(REQ_INIT, 8'd0, 16'd0, 2'd0);
        send_request(REQ_ALLOC, 8'd0, 16'd0, 2'd0);
        send_request(REQ_ALLOC, 8'd1, 16'd100, 2'd0);
        send_request(REQ_ALLOC, 8'd2, 16'd50, POL_BEST);
        send_request(REQ_ALLOC, 8'd3, 16'd100, POL_WORST);
        send_request(REQ_ALLOC, 8'd2, 16'd30, 2'd3);
        send_request(REQ_RELEASE, 8'd2, 16'hFFFF, 2'd3);
        send_request(REQ_RELEASE, 8'd1, 16'd0, 2'd0);
        send_request(REQ_ALLOC, 8'd4, 16'd40, POL_BEST);
        send_request(REQ_ALLOC, 8'd5, 16'd1024, 2'd0);
        send_request(REQ_RELEASE, 8'd3, 16'd0, 2'd0);
        send_request(REQ_RELEASE, 8'd2, 16'd0, 2'd0);
        send_request(REQ_RELEASE, 8'd4, 16'd0, 2'd0);
        send_request(REQ_RELEASE, 8'd7, 16'd0, 2'd0);
        send_request(REQ_ALLOC, 8'hFF, 16'd1024, POL_WORST);
        send_request(REQ_RELEASE, 8'hFF, 16'd0, POL_BEST);
        wait_drained();
    endtask

    // Fill the block table so an allocate is refused, then leave scattered holes.
    task automatic test_tables_full();
        write_config(CFG_BASE, 16'd0);
        write_config(CFG_LENGTH, 16'd64);
        send_request(REQ_INIT, 8'd0, 16'd0, 2'd0);
        for (int i = 0; i < 17; i++)
            send_request(REQ_ALLOC, 8'(i), 16'd2, 2'd0);
        // Freeing every other block leaves scattered holes.
        for (int i = 0; i < 16; i += 2)
            send_request(REQ_RELEASE, 8'(i), 16'd0, 2'd0);
        send_request(REQ_ALLOC, 8'd20, 16'd2, POL_BEST);
        wait_drained();
        write_config(CFG_LENGTH, 16'd40);
        send_request(REQ_INIT, 8'd0, 16'd0, 2'd0);
        for (int i = 0; i < 16; i++)
            send_request(REQ_ALLOC, 8'(i), (i == 15) ? 16'd10 : 16'd2, 2'd0);
        for (int i = 0; i < 16; i += 2)
            send_request(REQ_RELEASE, 8'(i), 16'd0, 2'd0);
        // Holes: the 8 freed blocks, no tail; a small allocate then splits the lowest one.
        send_request(REQ_ALLOC, 8'd0, 16'd1, 2'd0);
        wait_drained();
    endtask

    // Region extremes: a region cut at the top of the address space, zero length, maximum length.
    task automatic test_region_edges();
        write_config(CFG_BASE, 16'hFFF0);
        write_config(CFG_LENGTH, 16'hFFFF);
        send_request(REQ_INIT, 8'd0, 16'd0, 2'd0);
        send_request(REQ_ALLOC, 8'd9, 16'h0010, POL_BEST);
        send_request(REQ_RELEASE, 8'd9, 16'd0, 2'd0);
        wait_drained();
        write_config(CFG_LENGTH, 16'd0);
        send_request(REQ_INIT, 8'd0, 16'd0, 2'd0);
        send_request(REQ_ALLOC, 8'd9, 16'd1, 2'd0);
        wait_drained();
        write_config(CFG_BASE, 16'd0);
        write_config(CFG_LENGTH, 16'hFFFF);
        send_request(REQ_INIT, 8'd0, 16'd0, 2'd0);
        send_request(REQ_ALLOC, 8'd9, 16'hFFFF, POL_WORST);
        wait_drained();
    endtask

    // Random sessions of well-formed allocate/release traffic with a few oddities.
    task automatic run_random_session(int count, bit no_gap);
        logic [1:0]  kind;
        logic [15:0] size;
        int          r;
        send_request(REQ_INIT, 8'd0, 16'd0, 2'd0, no_gap);
        for (int n = 0; n < count; n++)
        begin
            r = $urandom_range(0, 99);
            if (r < 50)
                kind = REQ_ALLOC;
            else if (r < 92)
                kind = REQ_RELEASE;
            else if (r < 96)
                kind = 2'd3;
            else
                kind = REQ_INIT;
            r = $urandom_range(0, 19);
            if (r == 0)
                size = 16'($urandom());
            else if (r == 1)
                size = 16'd0;
            else
                size = 16'($urandom_range(1, (m_len >> 3) + 1));
            send_request(kind,
                         ($urandom_range(0, 9) == 0) ? 8'($urandom()) : 8'($urandom_range(0, 11)),
                         size, 2'($urandom()), no_gap);
        end
    endtask

    task automatic test_random();
        for (int phase = 0; phase < 12; phase++)
        begin
            wait_drained();
            write_config(CFG_BASE, 16'($urandom()));
            write_config(CFG_LENGTH, (phase % 3 == 0) ? 16'($urandom()) :
                         16'($urandom_range(16, 600)));
            run_random_session(140, phase == 5);
        end
        wait_drained();
    endtask

    // Long receiver hold-off while the sender keeps offering; then a session with no receiver stalls.
    task automatic test_backpressure();
        write_config(CFG_BASE, 16'h1000);
        write_config(CFG_LENGTH, 16'd512);
        long_hold <= 300;
        run_random_session(30, 1);
        wait_drained();
        quiet_out <= 1'b1;
        run_random_session(40, 1);
        wait_drained();
        quiet_out <= 1'b0;
    endtask

    initial
    begin
        for (int i = 0; i < NU; i++)
            u_used[i] = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_before_init();
        test_directed();
        test_tables_full();
        test_region_edges();
        test_backpressure();
        test_random();
        $display("Sent %0d items and checked %0d results.", items_sent, results_seen);
        $display("Granted %0d blocks and released %0d over a range of region settings.",
                 ok_allocs, ok_releases);
        if (mismatches == 0 && pending_grants.size() == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("tb_top: FAIL");
        $finish;
    end
endmodule
`default_nettype wire
